@@ src/i2cmbe_pkg.sv @@
`timescale 1ns / 1ps

package i2cmbe_pkg;

  localparam int WaitBits = 8;

  localparam logic [2:0] CmdNone    = 3'd0;
  localparam logic [2:0] OpStart    = 3'd1;
  localparam logic [2:0] OpStop     = 3'd2;
  localparam logic [2:0] OpWrite    = 3'd3;
  localparam logic [2:0] OpReadAck  = 3'd4;
  localparam logic [2:0] OpReadNak  = 3'd5;
  localparam logic [2:0] OpProbe    = 3'd6;

  localparam logic CfgPhase = 1'b0;
  localparam logic CfgSetup = 1'b1;

  localparam logic [7:0] PhaseReset = 8'd5;
  localparam logic [7:0] SetupReset = 8'd1;

  typedef enum logic [21:0] {
    StIdle = 22'h000001,
    StS0   = 22'h000002,
    StS1   = 22'h000004,
    StS2   = 22'h000008,
    StS3   = 22'h000010,
    StW0   = 22'h000020,
    StW1   = 22'h000040,
    StW2   = 22'h000080,
    StW3   = 22'h000100,
    StW4   = 22'h000200,
    StW5   = 22'h000400,
    StP0   = 22'h000800,
    StP1   = 22'h001000,
    StP2   = 22'h002000,
    StP3   = 22'h004000,
    StP4   = 22'h008000,
    StR0   = 22'h010000,
    StR1   = 22'h020000,
    StR2   = 22'h040000,
    StR3   = 22'h080000,
    StR4   = 22'h100000,
    StR5   = 22'h200000
  } step_e;

  typedef enum logic [1:0] {
    RunGo   = 2'd0,
    RunWait = 2'd1,
    RunEnd  = 2'd2
  } run_e;

  typedef struct packed {
    logic [2:0] op;
    logic       is_cmd;
    step_e      start;
    logic [7:0] data;
    logic       sda;
  } item_t;

  typedef struct packed {
    step_e                step;
    logic [3:0]           bit_idx;
    logic [7:0]           shreg;
    logic [WaitBits-1:0]  wait_cnt;
    logic [2:0]           cmd;
    logic                 scl;
    logic                 sda_drv;
    logic                 sda_out;
    logic [7:0]           rx;
    logic                 ack;
  } eng_t;

  typedef struct packed {
    eng_t e;
    run_e run;
  } step_res_t;

  typedef struct packed {
    logic       rejected;
    logic       ack;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       sda_value;
    logic       sda_drive;
    logic       scl;
  } result_t;

  localparam eng_t EngReset = '{
    step:     StIdle,
    bit_idx:  4'd0,
    shreg:    8'd0,
    wait_cnt: '0,
    cmd:      CmdNone,
    scl:      1'b1,
    sda_drv:  1'b1,
    sda_out:  1'b1,
    rx:       8'd0,
    ack:      1'b0
  };

  function automatic logic [WaitBits-1:0] load_delay(input logic [7:0] ticks);
    logic [16:0] d;
    d = (ticks == 8'd0) ? 17'd0 : (17'(ticks) - 17'd1);
    if (d > 17'((1 << WaitBits) - 1)) begin
      d = 17'((1 << WaitBits) - 1);
    end
    return d[WaitBits-1:0];
  endfunction

  function automatic step_res_t step_fn(input eng_t s, input logic sda,
                                        input logic [7:0] phase,
                                        input logic [7:0] setup);
    step_res_t  r;
    logic [3:0] nb;
    r.e   = s;
    r.run = RunWait;
    nb    = s.bit_idx + 4'd1;
    case (s.step)
      StS0: begin
        r.e.sda_drv = 1'b1; r.e.wait_cnt = load_delay(setup); r.e.step = StS1;
      end
      StS1: begin
        r.e.scl = 1'b1; r.e.sda_out = 1'b1;
        r.e.wait_cnt = load_delay(phase); r.e.step = StS2;
      end
      StS2: begin
        r.e.sda_out = 1'b0; r.e.wait_cnt = load_delay(phase); r.e.step = StS3;
      end
      StS3: begin
        r.e.scl = 1'b0;
        if (s.cmd == OpProbe) begin
          r.e.step = StW0; r.run = RunGo;
        end else begin
          r.run = RunEnd;
        end
      end
      StW0: begin
        r.e.sda_drv = 1'b1; r.e.bit_idx = 4'd0;
        r.e.wait_cnt = load_delay(setup); r.e.step = StW1;
      end
      StW1: begin
        r.e.sda_out = s.shreg[7]; r.e.wait_cnt = load_delay(phase); r.e.step = StW2;
      end
      StW2: begin
        r.e.scl = 1'b1; r.e.wait_cnt = load_delay(phase); r.e.step = StW3;
      end
      StW3: begin
        r.e.scl = 1'b0;
        r.e.shreg = {s.shreg[6:0], 1'b0};
        r.e.bit_idx = nb;
        if (nb < 4'd8) begin
          r.e.step = StW1; r.run = RunGo;
        end else begin
          r.e.sda_out = 1'b1; r.e.sda_drv = 1'b0;
          r.e.wait_cnt = load_delay(phase); r.e.step = StW4;
        end
      end
      StW4: begin
        r.e.scl = 1'b1; r.e.wait_cnt = load_delay(phase); r.e.step = StW5;
      end
      StW5: begin
        r.e.ack = ~sda; r.e.scl = 1'b0;
        if (s.cmd == OpProbe) begin
          r.e.step = StP0; r.run = RunGo;
        end else begin
          r.run = RunEnd;
        end
      end
      StP0: begin
        r.e.sda_drv = 1'b1; r.e.wait_cnt = load_delay(setup); r.e.step = StP1;
      end
      StP1: begin
        r.e.scl = 1'b0; r.e.sda_out = 1'b0;
        r.e.wait_cnt = load_delay(phase); r.e.step = StP2;
      end
      StP2: begin
        r.e.scl = 1'b1; r.e.wait_cnt = load_delay(phase); r.e.step = StP3;
      end
      StP3: begin
        r.e.sda_out = 1'b1; r.e.wait_cnt = load_delay(phase); r.e.step = StP4;
      end
      StR0: begin
        r.e.sda_out = 1'b1; r.e.sda_drv = 1'b0; r.e.bit_idx = 4'd0;
        r.e.wait_cnt = load_delay(phase); r.e.step = StR1;
      end
      StR1: begin
        r.e.scl = 1'b1; r.e.shreg = {s.shreg[6:0], sda};
        r.e.wait_cnt = load_delay(phase); r.e.step = StR2;
      end
      StR2: begin
        r.e.scl = 1'b0; r.e.bit_idx = nb;
        if (nb < 4'd8) begin
          r.e.wait_cnt = load_delay(phase); r.e.step = StR1;
        end else begin
          r.e.sda_drv = 1'b1; r.e.wait_cnt = load_delay(setup); r.e.step = StR3;
        end
      end
      StR3: begin
        r.e.sda_out = (s.cmd == OpReadNak);
        r.e.wait_cnt = load_delay(phase); r.e.step = StR4;
      end
      StR4: begin
        r.e.scl = 1'b1; r.e.wait_cnt = load_delay(phase); r.e.step = StR5;
      end
      StR5: begin
        r.e.scl = 1'b0; r.e.rx = s.shreg; r.run = RunEnd;
      end
      default: begin
        r.run = RunEnd;
      end
    endcase
    return r;
  endfunction

endpackage

@@ src/i2cmbe_front.sv @@
`timescale 1ns / 1ps

module i2cmbe_front (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [15:0]        s_axis_tdata_i,
  input  logic [2:0]         s_axis_tuser_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output i2cmbe_pkg::item_t  push_item_o
);

  logic [2:0] op;

  assign op = s_axis_tuser_i;

  always_comb begin
    push_item_o.op     = op;
    push_item_o.data   = s_axis_tdata_i[7:0];
    push_item_o.sda    = s_axis_tdata_i[8];
    push_item_o.is_cmd = (op >= i2cmbe_pkg::OpStart) && (op <= i2cmbe_pkg::OpProbe);
    case (op)
      i2cmbe_pkg::OpStart,
      i2cmbe_pkg::OpProbe:   push_item_o.start = i2cmbe_pkg::StS0;
      i2cmbe_pkg::OpStop:    push_item_o.start = i2cmbe_pkg::StP0;
      i2cmbe_pkg::OpWrite:   push_item_o.start = i2cmbe_pkg::StW0;
      i2cmbe_pkg::OpReadAck,
      i2cmbe_pkg::OpReadNak: push_item_o.start = i2cmbe_pkg::StR0;
      default:               push_item_o.start = i2cmbe_pkg::StIdle;
    endcase
  end

  assign push_valid_o    = s_axis_tvalid_i;
  assign s_axis_tready_o = push_ready_i;

endmodule

@@ src/i2cmbe_queue.sv @@
`timescale 1ns / 1ps

module i2cmbe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  i2cmbe_pkg::item_t  push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output i2cmbe_pkg::item_t  pop_item_o
);

  i2cmbe_pkg::item_t mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ src/i2cmbe_back.sv @@
`timescale 1ns / 1ps

module i2cmbe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  i2cmbe_pkg::item_t  pop_item_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [15:0]        m_axis_tdata_o
);

  logic [7:0]                phase_q, setup_q;
  i2cmbe_pkg::eng_t          eng_q, eng_d, eng_in;
  i2cmbe_pkg::step_res_t     r1, r2;
  i2cmbe_pkg::result_t       res_d;
  i2cmbe_pkg::result_t       mem_q [2];
  logic                      wr_ptr_q, wr_ptr_d;
  logic                      rd_ptr_q, rd_ptr_d;
  logic [1:0]                cnt_q, cnt_d;
  logic                      proc, pop;
  logic                      rejected, done;

  assign pop_ready_o = (cnt_q != 2'd2);
  assign proc        = pop_valid_i && pop_ready_o;

  // A command is taken only when the engine is idle; it then runs on the same tick.
  always_comb begin
    eng_in   = eng_q;
    rejected = 1'b0;
    if (eng_q.cmd == i2cmbe_pkg::CmdNone) begin
      if (pop_item_i.is_cmd) begin
        eng_in.cmd      = pop_item_i.op;
        eng_in.shreg    = pop_item_i.data;
        eng_in.wait_cnt = '0;
        eng_in.step     = pop_item_i.start;
      end
    end else if (pop_item_i.is_cmd) begin
      rejected = 1'b1;
    end
  end

  assign r1 = i2cmbe_pkg::step_fn(eng_in, pop_item_i.sda, phase_q, setup_q);
  assign r2 = i2cmbe_pkg::step_fn(r1.e, pop_item_i.sda, phase_q, setup_q);

  always_comb begin
    eng_d = eng_in;
    done  = 1'b0;
    if (eng_in.cmd != i2cmbe_pkg::CmdNone) begin
      if (eng_in.wait_cnt != '0) begin
        eng_d.wait_cnt = eng_in.wait_cnt - 1'b1;
      end else if (r1.run == i2cmbe_pkg::RunWait) begin
        eng_d = r1.e;
      end else if (r1.run == i2cmbe_pkg::RunEnd || r2.run == i2cmbe_pkg::RunEnd) begin
        eng_d          = (r1.run == i2cmbe_pkg::RunEnd) ? r1.e : r2.e;
        done           = 1'b1;
        eng_d.cmd      = i2cmbe_pkg::CmdNone;
        eng_d.step     = i2cmbe_pkg::StIdle;
        eng_d.wait_cnt = '0;
      end else begin
        eng_d = r2.e;
      end
    end
  end

  always_comb begin
    res_d.scl       = eng_d.scl;
    res_d.sda_drive = eng_d.sda_drv;
    res_d.sda_value = eng_d.sda_out;
    res_d.busy      = (eng_d.cmd != i2cmbe_pkg::CmdNone);
    res_d.done      = done;
    res_d.rx        = eng_d.rx;
    res_d.ack       = eng_d.ack;
    res_d.rejected  = rejected;
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {1'b0, mem_q[rd_ptr_q]};
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    wr_ptr_d = proc ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, proc} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2cmbe_pkg::PhaseReset;
      setup_q  <= i2cmbe_pkg::SetupReset;
      eng_q    <= i2cmbe_pkg::EngReset;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (cfg_we_i && cfg_index_i == i2cmbe_pkg::CfgPhase) begin
        phase_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == i2cmbe_pkg::CfgSetup) begin
        setup_q <= cfg_data_i;
      end
      if (proc) begin
        eng_q <= eng_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

endmodule

@@ src/i2c_master_byte_engine_top.sv @@
`timescale 1ns / 1ps

// I2C master byte engine. Every input item is one bus timing tick of about one
// microsecond; its tuser field may carry a command (start, stop, write, read with
// ACK or NAK, address probe) that begins on that same tick when the engine is idle.
// Each input item produces exactly one output item holding the SCL and SDA pin
// controls, busy and done flags, the last received byte, the acknowledge seen and
// a flag for a command that was ignored because the engine was busy.
// Phase and settle delays are set through the write port, register 0 being the
// phase delay and register 1 the settle delay. They are to be written only while
// idle by the user; the block does not enforce this. An accepted item is held
// in the command queue; the engine runs it from there and registers the result
// into a two-entry output buffer, from which the receiver takes it. The engine
// completes one tick per clock while the output buffer has room, so one item per
// cycle is sustained as long as the receiver keeps taking results.
// Reset returns the engine to idle with SCL high and SDA driven high, and loads
// the delay registers with five and one ticks.
// When the receiver stalls, the output buffer fills, then the command queue, and
// s_axis_tready_o falls; no item is lost or repeated.
module i2c_master_byte_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // data_byte [7:0], sda_level [8], zero [15:9]
  input  logic [15:0] s_axis_tdata_i,
  // op [2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scl_level [0], sda_drive [1], sda_value [2], busy_res [3], done_res [4],
  // rx_byte [12:5], ack_seen [13], rejected [14], zero [15]
  output logic [15:0] m_axis_tdata_o
);

  logic              push_valid, push_ready;
  i2cmbe_pkg::item_t push_item;
  logic              pop_valid, pop_ready;
  i2cmbe_pkg::item_t pop_item;

  i2cmbe_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  i2cmbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  i2cmbe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (pop_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

@@ src/i2cmbe_checker.sv @@
`timescale 1ns / 1ps

module i2cmbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A stalled output item keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped during stall");

  // A stalled output item keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed during stall");

  // A command that finishes leaves the engine idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[3] && m_axis_tdata_o[4]))
    else $error("done and busy reported together");

  // The input side only backs up behind pending output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o))
    else $error("input stalled without pending output");

endmodule

bind i2c_master_byte_engine_top i2cmbe_checker u_i2cmbe_checker (.*);
